// File: hdl/cob_pkg.sv
package cob_pkg;

    localparam int IDX_W      = 12;
    localparam int WORD_W     = 32;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int ADDR_W     = 16;
    localparam int POS_W      = 17;
    localparam int Q_DEPTH    = 4;
    // front stages + queue + back stages + output register
    localparam int PIPE_CAP   = Q_DEPTH + 5;

    localparam logic KIND_IMAGE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOTSPOT_COL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOTSPOT_ROW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ENABLE = 3'd6;

    typedef struct packed {
        logic              kind;
        logic              act;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        pad;
        logic              rs;
        logic              fs;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // exact x/255 for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        logic [16:0] s;
        t = 17'(x) + 17'd1;
        s = t + (t >> 8);
        return s[15:8];
    endfunction

endpackage

// File: hdl/cob_front.sv
module cob_front #(
    parameter int CURSOR_DIM      = 64,
    parameter int MAX_SURFACE_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_kind,
    input  logic [cob_pkg::IDX_W-1:0]     i_image_index,
    input  logic [cob_pkg::WORD_W-1:0]    i_image_word,
    input  logic [7:0]                    i_src_red,
    input  logic [7:0]                    i_src_green,
    input  logic [7:0]                    i_src_blue,
    input  logic [7:0]                    i_src_pad,
    input  logic                          i_row_start,
    input  logic                          i_frame_start,
    input  logic                          i_cfg_we,
    input  logic [cob_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cob_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_q_push,
    output cob_pkg::t_qent                o_q_ent,
    input  cob_pkg::t_qstat               i_q_stat
);
    import cob_pkg::*;

    localparam int CW = $clog2(MAX_SURFACE_DIM);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SURFACE_DIM - 1);
    localparam logic [8:0] CDIM9 = 9'(CURSOR_DIM);
    localparam int DEPTH = CURSOR_DIM * CURSOR_DIM;

    logic signed [12:0] r_cx, r_cy;
    logic [5:0]  r_hc, r_hr;
    logic [6:0]  r_w, r_h;
    logic        r_en;

    logic [CW-1:0] r_col, r_row, n_col, n_row;

    logic              r_s1_valid;
    logic              r_s1_kind;
    logic [IDX_W-1:0]  r_s1_index;
    logic [WORD_W-1:0] r_s1_word;
    logic [7:0]        r_s1_red, r_s1_green, r_s1_blue, r_s1_pad;
    logic              r_s1_rs, r_s1_fs;
    logic [CW-1:0]     r_s1_col, r_s1_row;

    logic              r_s2_valid;
    logic              r_s2_kind;
    logic              r_s2_act;
    logic [IDX_W-1:0]  r_s2_index;
    logic [WORD_W-1:0] r_s2_word;
    logic [7:0]        r_s2_red, r_s2_green, r_s2_blue, r_s2_pad;
    logic              r_s2_rs, r_s2_fs;
    logic [6:0]        r_s2_dx, r_s2_dy;

    logic stall, adv, acc;
    logic [6:0] wc, hc;
    logic signed [POS_W-1:0] dx, dy, wcx, hcx;
    logic in_x, in_y, act;
    logic [14:0] pix_addr;

    assign stall  = r_s2_valid && i_q_stat.full;
    assign adv    = !stall;
    assign acc    = i_push && !stall;
    assign o_full = stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_hc <= '0;
            r_hr <= '0;
            r_w  <= '0;
            r_h  <= '0;
            r_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CURSOR_X:      r_cx <= $signed(i_cfg_data);
                REG_CURSOR_Y:      r_cy <= $signed(i_cfg_data);
                REG_HOTSPOT_COL:   r_hc <= i_cfg_data[5:0];
                REG_HOTSPOT_ROW:   r_hr <= i_cfg_data[5:0];
                REG_CURSOR_WIDTH:  r_w  <= i_cfg_data[6:0];
                REG_CURSOR_HEIGHT: r_h  <= i_cfg_data[6:0];
                REG_CURSOR_ENABLE: r_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // raster position, saturating at the surface edge
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_kind == KIND_PIXEL) begin
            priority if (i_frame_start) begin
                n_col = '0;
                n_row = '0;
            end else if (i_row_start) begin
                n_col = '0;
                n_row = (r_row == CNT_MAX) ? r_row : r_row + CW'(1);
            end else begin
                n_col = (r_col == CNT_MAX) ? r_col : r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind  <= i_kind;
            r_s1_index <= i_image_index;
            r_s1_word  <= i_image_word;
            r_s1_red   <= i_src_red;
            r_s1_green <= i_src_green;
            r_s1_blue  <= i_src_blue;
            r_s1_pad   <= i_src_pad;
            r_s1_rs    <= i_row_start;
            r_s1_fs    <= i_frame_start;
            r_s1_col   <= n_col;
            r_s1_row   <= n_row;
        end
    end

    assign wc = ({2'b00, r_w} > CDIM9) ? CDIM9[6:0] : r_w;
    assign hc = ({2'b00, r_h} > CDIM9) ? CDIM9[6:0] : r_h;

    assign wcx = $signed({{(POS_W-7){1'b0}}, wc});
    assign hcx = $signed({{(POS_W-7){1'b0}}, hc});

    assign dx = $signed({{(POS_W-CW){1'b0}}, r_s1_col}) - POS_W'(r_cx)
              + $signed({{(POS_W-6){1'b0}}, r_hc});
    assign dy = $signed({{(POS_W-CW){1'b0}}, r_s1_row}) - POS_W'(r_cy)
              + $signed({{(POS_W-6){1'b0}}, r_hr});

    assign in_x = !dx[POS_W-1] && (dx < wcx);
    assign in_y = !dy[POS_W-1] && (dy < hcx);

    always_comb begin
        if (r_s1_kind == KIND_PIXEL) begin
            act = r_en && (wc != '0) && (hc != '0) && in_x && in_y;
        end else begin
            act = 32'(r_s1_index) < 32'(DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_act   <= act;
            r_s2_index <= r_s1_index;
            r_s2_word  <= r_s1_word;
            r_s2_red   <= r_s1_red;
            r_s2_green <= r_s1_green;
            r_s2_blue  <= r_s1_blue;
            r_s2_pad   <= r_s1_pad;
            r_s2_rs    <= r_s1_rs;
            r_s2_fs    <= r_s1_fs;
            r_s2_dx    <= dx[6:0];
            r_s2_dy    <= dy[6:0];
        end
    end

    assign pix_addr = 15'(r_s2_dy * wc) + 15'(r_s2_dx);

    assign o_q_push = adv && r_s2_valid;

    always_comb begin
        o_q_ent.kind  = r_s2_kind;
        o_q_ent.act   = r_s2_act;
        o_q_ent.addr  = (r_s2_kind == KIND_PIXEL) ? ADDR_W'(pix_addr) : ADDR_W'(r_s2_index);
        o_q_ent.word  = r_s2_word;
        o_q_ent.red   = r_s2_red;
        o_q_ent.green = r_s2_green;
        o_q_ent.blue  = r_s2_blue;
        o_q_ent.pad   = r_s2_pad;
        o_q_ent.rs    = r_s2_rs;
        o_q_ent.fs    = r_s2_fs;
    end

endmodule

// File: hdl/cob_queue.sv
module cob_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cob_pkg::t_qent  i_ent,
    input  logic            i_pop,
    output cob_pkg::t_qent  o_ent,
    output cob_pkg::t_qstat o_stat
);
    import cob_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int NW = $clog2(Q_DEPTH + 1);

    t_qent         r_ent [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == NW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_ent   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_ent;
        end
    end

endmodule

// File: hdl/cob_back.sv
module cob_back #(
    parameter int CURSOR_DIM = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cob_pkg::t_qent  i_q_ent,
    input  cob_pkg::t_qstat i_q_stat,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_blue,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_pad,
    output logic            o_out_row_start,
    output logic            o_out_frame_start
);
    import cob_pkg::*;

    localparam int DEPTH = CURSOR_DIM * CURSOR_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    logic              adv;
    logic              r_b1_valid, r_b1_act, r_b1_rs, r_b1_fs;
    logic [7:0]        r_b1_red, r_b1_green, r_b1_blue, r_b1_pad;
    logic [WORD_W-1:0] r_word;

    logic              r_b2_valid, r_b2_rs, r_b2_fs;
    logic [7:0]        r_b2_pad;
    logic [15:0]       r_pr_c, r_pr_b, r_pg_c, r_pg_b, r_pb_c, r_pb_b;

    logic              r_o_valid;
    logic [WORD_W-1:0] w_eff;
    logic [7:0]        a_eff, a_inv;

    assign adv     = !r_o_valid || i_pop;
    assign o_q_pop = adv && !i_q_stat.empty;
    assign o_empty = !r_o_valid;

    // image writes and pixel reads leave the queue in order, one a cycle while the back end is not stalled
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_q_ent.kind == KIND_IMAGE) begin
                if (i_q_ent.act) begin
                    mem[i_q_ent.addr[AW-1:0]] <= i_q_ent.word;
                end
            end else begin
                r_word <= mem[i_q_ent.addr[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_b1_valid <= o_q_pop && (i_q_ent.kind == KIND_PIXEL);
            r_b2_valid <= r_b1_valid;
            r_o_valid  <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_act   <= i_q_ent.act;
            r_b1_red   <= i_q_ent.red;
            r_b1_green <= i_q_ent.green;
            r_b1_blue  <= i_q_ent.blue;
            r_b1_pad   <= i_q_ent.pad;
            r_b1_rs    <= i_q_ent.rs;
            r_b1_fs    <= i_q_ent.fs;
        end
    end

    // outside the cursor the word is forced to zero, whatever the memory holds;
    // zero alpha gives bg*255/255, i.e. the source pixel
    assign w_eff = r_b1_act ? r_word : '0;
    assign a_eff = w_eff[31:24];
    assign a_inv = 8'd255 - a_eff;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pr_c   <= w_eff[7:0]   * a_eff;
            r_pg_c   <= w_eff[15:8]  * a_eff;
            r_pb_c   <= w_eff[23:16] * a_eff;
            r_pr_b   <= r_b1_red   * a_inv;
            r_pg_b   <= r_b1_green * a_inv;
            r_pb_b   <= r_b1_blue  * a_inv;
            r_b2_pad <= r_b1_pad;
            r_b2_rs  <= r_b1_rs;
            r_b2_fs  <= r_b1_fs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_blue        <= div255(r_pb_c + r_pb_b);
            o_out_green       <= div255(r_pg_c + r_pg_b);
            o_out_red         <= div255(r_pr_c + r_pr_b);
            o_out_pad         <= r_b2_pad;
            o_out_row_start   <= r_b2_rs;
            o_out_frame_start <= r_b2_fs;
        end
    end

endmodule

// File: hdl/cursor_overlay_blend.sv
// Cursor overlay blender.
// Input side is a queue: present an item and raise push; it is taken on a
// clock edge where full is low. kind 0 stores image_word in the cursor
// memory at image_index, kind 1 is a frame pixel in RGBX order.
// Result side is a queue too: while empty is low the oldest BGRX pixel sits
// on the o_out_* ports and is taken on an edge with pop high. Image writes
// give no result.
// Throughput is one item per clock when nothing stalls. A taken pixel passes
// two front stages (position, rectangle test and address), the decoupling
// queue, cursor memory read, multiply, then the divide-by-255 into the
// output register.
// Cursor registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// with the block idle.
// Reset clears position counters, registers and all valid flags; cursor
// memory is not cleared. If pop is held low the back end stops, the
// 4-entry queue fills and full rises; nothing is dropped.
module cursor_overlay_blend #(
    parameter int CURSOR_DIM      = 64,
    parameter int MAX_SURFACE_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_kind,
    input  logic [cob_pkg::IDX_W-1:0]     i_image_index,
    input  logic [cob_pkg::WORD_W-1:0]    i_image_word,
    input  logic [7:0]                    i_src_red,
    input  logic [7:0]                    i_src_green,
    input  logic [7:0]                    i_src_blue,
    input  logic [7:0]                    i_src_pad,
    input  logic                          i_row_start,
    input  logic                          i_frame_start,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_out_blue,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_pad,
    output logic                          o_out_row_start,
    output logic                          o_out_frame_start,
    input  logic                          i_cfg_we,
    input  logic [cob_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cob_pkg::CFG_W-1:0]     i_cfg_data
);
    import cob_pkg::*;

    logic   q_push, q_pop;
    t_qent  q_in, q_out;
    t_qstat q_stat;

    cob_front #(
        .CURSOR_DIM      (CURSOR_DIM),
        .MAX_SURFACE_DIM (MAX_SURFACE_DIM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_image_index (i_image_index),
        .i_image_word  (i_image_word),
        .i_src_red     (i_src_red),
        .i_src_green   (i_src_green),
        .i_src_blue    (i_src_blue),
        .i_src_pad     (i_src_pad),
        .i_row_start   (i_row_start),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_q_push      (q_push),
        .o_q_ent       (q_in),
        .i_q_stat      (q_stat)
    );

    cob_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .i_pop   (q_pop),
        .o_ent   (q_out),
        .o_stat  (q_stat)
    );

    cob_back #(
        .CURSOR_DIM (CURSOR_DIM)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_ent           (q_out),
        .i_q_stat          (q_stat),
        .o_q_pop           (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_out_blue        (o_out_blue),
        .o_out_green       (o_out_green),
        .o_out_red         (o_out_red),
        .o_out_pad         (o_out_pad),
        .o_out_row_start   (o_out_row_start),
        .o_out_frame_start (o_out_frame_start)
    );

endmodule

// File: hdl/cob_checker.sv
module cob_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       i_kind,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_blue,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_pad,
    input logic       o_out_row_start,
    input logic       o_out_frame_start
);
    import cob_pkg::*;

    localparam int PCW = $clog2(PIPE_CAP + 2);

    logic [PCW-1:0] r_pend;
    logic           pix_in, pix_out;

    assign pix_in  = push && !full && (i_kind == KIND_PIXEL);
    assign pix_out = pop && !empty;

    // pixels taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            unique case ({pix_in, pix_out})
                2'b10:   r_pend <= r_pend + PCW'(1);
                2'b01:   r_pend <= r_pend - PCW'(1);
                default: r_pend <= r_pend;
            endcase
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("outputs not idle after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_pend != '0)
        else $error("result shown with no pixel outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PCW'(PIPE_CAP))
        else $error("more pixels in flight than the pipeline holds");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_blue) && $stable(o_out_green)
            && $stable(o_out_red) && $stable(o_out_pad)
            && $stable(o_out_row_start) && $stable(o_out_frame_start))
        else $error("stalled result changed");

endmodule

bind cursor_overlay_blend cob_checker u_cob_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .push              (push),
    .full              (full),
    .i_kind            (i_kind),
    .empty             (empty),
    .pop               (pop),
    .o_out_blue        (o_out_blue),
    .o_out_green       (o_out_green),
    .o_out_red         (o_out_red),
    .o_out_pad         (o_out_pad),
    .o_out_row_start   (o_out_row_start),
    .o_out_frame_start (o_out_frame_start)
);
